@@ rtl/core/lcmw_pkg.sv @@
// Shared types and constants for the load-cell median weigher.
// No dependencies.
package lcmw_pkg;

    localparam int unsigned Window = 7;
    localparam int unsigned WinIdxW = $clog2(Window);
    localparam int unsigned WinCntW = $clog2(Window + 1);
    localparam int unsigned SampleW = 24;
    localparam int unsigned WeightW = 32;
    localparam int unsigned QuotW = 64;

    localparam logic [2:0] RegEnable = 3'd0;
    localparam logic [2:0] RegTare = 3'd1;
    localparam logic [2:0] RegSlope = 3'd2;
    localparam logic [2:0] RegVariance = 3'd3;
    localparam logic [2:0] RegLimit = 3'd4;

    typedef struct packed {
        logic                 start;
        logic signed [63:0]   num;
        logic signed [63:0]   den;
    } lcmw_div_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [63:0]   quot;
    } lcmw_div_rsp_t;

endpackage

@@ rtl/core/load_cell_median_weigher_unit.sv @@
// Top level of the load-cell median weigher: sample window, median sequencer,
// conversion and change tracking. Depends on lcmw_pkg and lcmw_divider.
//
// Samples are stored as they arrive while enabled, one per cycle while the
// input is ready. When a batch of Window samples is complete, the median is
// found by a rank count that compares one pair of samples per cycle. The weight
// is then found with a divider of 64 iterations (StDivGo, StDiv), which is
// skipped when the slope is zero. Change tracking (StPost) and the load of the
// result register (StOut) follow. A completing sample therefore keeps the input
// from being ready until the result register is loaded, and longer while an
// earlier result still waits in the result register. Other samples are accepted
// without holding the input.
module load_cell_median_weigher_unit
    import lcmw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // weight_grams, median_counts, weight_changing, slope_error
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [5:0] {
        StIdle  = 6'b000001,
        StRank  = 6'b000010,
        StDivGo = 6'b000100,
        StDiv   = 6'b001000,
        StPost  = 6'b010000,
        StOut   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic               en_reg;
    logic signed [23:0] tare_reg;
    logic signed [31:0] slope_reg;
    logic [15:0]        var_reg;
    logic [7:0]         lim_reg;

    logic signed [23:0] win_mem [Window];
    logic [WinCntW-1:0] bcnt_reg, bcnt_next;
    logic [WinIdxW-1:0] ia_reg, ia_next, ib_reg, ib_next;
    logic [WinCntW-1:0] lt_reg, lt_next, le_reg, le_next;
    logic signed [23:0] med_reg, med_next;
    logic signed [31:0] prev_reg, prev_next;
    logic [7:0]         ucnt_reg, ucnt_next;
    logic               flag_reg, flag_next;
    logic signed [31:0] w_reg, w_next;
    logic               err_reg, err_next;
    logic [63:0]        out_reg, out_next;
    logic               ov_reg, ov_next;

    lcmw_div_req_t div_req;
    lcmw_div_rsp_t div_rsp;

    logic signed [23:0] va, vb;
    logic               s_acc;
    logic signed [63:0] d64, qsat;
    logic signed [32:0] diff;
    logic [32:0]        adiff;
    logic               flag_t;

    lcmw_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    assign s_tready = (state_reg == StIdle);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (s_acc && en_reg) begin
            win_mem[bcnt_reg[WinIdxW-1:0]] <= s_tdata;
        end
    end

    assign va  = win_mem[ia_reg];
    assign vb  = win_mem[ib_reg];
    assign d64 = 64'(signed'({{40{med_reg[23]}}, med_reg}) - signed'({{40{tare_reg[23]}}, tare_reg}));

    always_comb begin
        div_req.start = (state_reg == StDivGo);
        div_req.num   = (d64 <<< 17) + 64'(slope_reg);
        div_req.den   = 64'(slope_reg) <<< 1;
    end

    always_comb begin
        state_next = state_reg;
        bcnt_next  = bcnt_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        lt_next    = lt_reg;
        le_next    = le_reg;
        med_next   = med_reg;
        prev_next  = prev_reg;
        ucnt_next  = ucnt_reg;
        flag_next  = flag_reg;
        w_next     = w_reg;
        err_next   = err_reg;
        out_next   = out_reg;
        ov_next    = ov_reg && !m_tready;
        if (div_rsp.quot > 64'sd2147483647) begin
            qsat = 64'sd2147483647;
        end else if (div_rsp.quot < -64'sd2147483648) begin
            qsat = -64'sd2147483648;
        end else begin
            qsat = div_rsp.quot;
        end
        diff   = 33'(w_reg) - 33'(prev_reg);
        adiff  = diff[32] ? 33'(-diff) : diff;
        flag_t = flag_reg;
        unique case (state_reg)
            StIdle: begin
                if (s_acc && en_reg) begin
                    if (bcnt_reg == WinCntW'(Window - 1)) begin
                        bcnt_next  = '0;
                        ia_next    = '0;
                        ib_next    = '0;
                        lt_next    = '0;
                        le_next    = '0;
                        state_next = StRank;
                    end else begin
                        bcnt_next = bcnt_reg + 1'b1;
                    end
                end
            end
            StRank: begin
                if (vb < va) lt_next = lt_reg + 1'b1;
                if (vb <= va) le_next = le_reg + 1'b1;
                if (ib_reg == WinIdxW'(Window - 1)) begin
                    ib_next = '0;
                    lt_next = '0;
                    le_next = '0;
                    if (((vb < va) ? lt_reg + 1'b1 : lt_reg) <= WinCntW'(Window / 2) &&
                        ((vb <= va) ? le_reg + 1'b1 : le_reg) > WinCntW'(Window / 2)) begin
                        med_next = va;
                    end
                    if (ia_reg == WinIdxW'(Window - 1)) begin
                        state_next = StDivGo;
                    end else begin
                        ia_next = ia_reg + 1'b1;
                    end
                end else begin
                    ib_next = ib_reg + 1'b1;
                end
            end
            StDivGo: begin
                if (slope_reg == '0) begin
                    w_next     = prev_reg;
                    err_next   = 1'b1;
                    state_next = StPost;
                end else begin
                    err_next   = 1'b0;
                    state_next = StDiv;
                end
            end
            StDiv: begin
                if (div_rsp.done) begin
                    w_next     = qsat[31:0];
                    state_next = StPost;
                end
            end
            StPost: begin
                if (adiff > 33'(var_reg)) begin
                    flag_t    = 1'b1;
                    ucnt_next = 8'd1;
                    if (8'd0 > lim_reg) flag_t = 1'b0;
                end else begin
                    if (ucnt_reg > lim_reg) flag_t = 1'b0;
                    if (ucnt_reg != 8'hFF) ucnt_next = ucnt_reg + 8'd1;
                end
                flag_next  = flag_t;
                prev_next  = w_reg;
                state_next = StOut;
            end
            StOut: begin
                if (!ov_reg || m_tready) begin
                    out_next   = {6'd0, err_reg, flag_reg, med_reg, prev_reg};
                    ov_next    = 1'b1;
                    state_next = StIdle;
                end
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StIdle;
            en_reg    <= 1'b1;
            tare_reg  <= '0;
            slope_reg <= 32'sd65536;
            var_reg   <= 16'd100;
            lim_reg   <= 8'd10;
            bcnt_reg  <= '0;
            prev_reg  <= '0;
            ucnt_reg  <= '0;
            flag_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            bcnt_reg  <= bcnt_next;
            prev_reg  <= prev_next;
            ucnt_reg  <= ucnt_next;
            flag_reg  <= flag_next;
            ov_reg    <= ov_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    RegEnable:   en_reg    <= cfg_data[0];
                    RegTare:     tare_reg  <= cfg_data[23:0];
                    RegSlope:    slope_reg <= cfg_data;
                    RegVariance: var_reg   <= cfg_data[15:0];
                    RegLimit:    lim_reg   <= cfg_data[7:0];
                    default:     ;
                endcase
            end
        end
        ia_reg  <= ia_next;
        ib_reg  <= ib_next;
        lt_reg  <= lt_next;
        le_reg  <= le_next;
        med_reg <= med_next;
        w_reg   <= w_next;
        err_reg <= err_next;
        out_reg <= out_next;
    end

endmodule

@@ rtl/core/lcmw_divider.sv @@
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating.
// Depends on lcmw_pkg.
module lcmw_divider
    import lcmw_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  lcmw_div_req_t req,
    output lcmw_div_rsp_t rsp
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [63:0] shifted;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[62:0], quo_reg[63]};
        trial     = {1'b0, shifted} - {1'b0, dvs_reg};
        if (req.start) begin
            quo_next  = req.num[63] ? 64'(-req.num) : req.num;
            dvs_next  = req.den[63] ? 64'(-req.den) : req.den;
            neg_next  = req.num[63] ^ req.den[63];
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = neg_reg ? 64'(-quo_reg) : quo_reg;

endmodule

@@ bench/load_cell_median_weigher_unit_test.sv @@
// Self-checking bench for load_cell_median_weigher_unit: drives sample transactions,
// predicts each batch report in-bench and compares every result transaction.
// Depends on lcmw_pkg and the RTL of the weigher.
`timescale 1ns / 100ps

module load_cell_median_weigher_unit_test;
    import lcmw_pkg::*;

    localparam int SettleCycles = 200;
    localparam int StallLimit = 20000;

    typedef struct {
        logic signed [31:0] weight;
        logic signed [23:0] median;
        logic               changing;
        logic               slope_err;
    } weigh_report_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    weigh_report_t pending_reports[$];
    int  error_count;
    int  quiet_cycles;
    int  hold_off_cycles;
    bit  tx_idling;
    bit  rx_idling;

    // Shadow of the configuration and of the batch state.
    bit                 en_q;
    logic signed [23:0] tare_q;
    logic signed [31:0] slope_q;
    logic [15:0]        variance_q;
    logic [7:0]         limit_q;
    logic signed [23:0] batch_buf[Window];
    int                 batch_fill;
    logic signed [31:0] prior_weight;
    int                 reports_since_change;
    bit                 change_on;

    load_cell_median_weigher_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic signed [23:0] batch_median();
        logic signed [23:0] s[Window];
        logic signed [23:0] v;
        int j;
        for (int i = 0; i < Window; i++) begin
            v = batch_buf[i];
            j = i;
            while (j > 0 && s[j - 1] > v) begin
                s[j] = s[j - 1];
                j--;
            end
            s[j] = v;
        end
        return s[Window / 2];
    endfunction

    function automatic logic signed [31:0] counts_to_grams(input logic signed [23:0] med);
        longint d;
        longint num;
        longint den;
        longint q;
        d = longint'(med) - longint'(tare_q);
        num = d * 131072 + longint'(slope_q);
        den = longint'(slope_q) * 2;
        q = num / den;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    task automatic weigh_sample(input logic [23:0] sample);
        weigh_report_t r;
        longint diff;
        if (!en_q) return;
        batch_buf[batch_fill] = sample;
        batch_fill++;
        if (batch_fill < Window) return;
        batch_fill = 0;
        r.median = batch_median();
        r.slope_err = (slope_q == 0);
        r.weight = r.slope_err ? prior_weight : counts_to_grams(r.median);
        diff = longint'(r.weight) - longint'(prior_weight);
        if (diff < 0) diff = -diff;
        if (diff > longint'(variance_q)) begin
            change_on = 1'b1;
            reports_since_change = 0;
        end
        if (reports_since_change > int'(limit_q)) change_on = 1'b0;
        if (reports_since_change < 255) reports_since_change++;
        prior_weight = r.weight;
        r.changing = change_on;
        pending_reports.push_back(r);
    endtask

    task automatic send_sample(input logic [23:0] sample);
        if (tx_idling && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 40);
        end
        s_tvalid <= 1'b1;
        s_tdata <= sample;
        do @(posedge aclk); while (!s_tready);
        weigh_sample(sample);
    endtask

    task automatic wait_for_reports();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        wait_for_reports();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            RegEnable:   en_q = value[0];
            RegTare:     tare_q = value[23:0];
            RegSlope:    slope_q = value;
            RegVariance: variance_q = value[15:0];
            RegLimit:    limit_q = value[7:0];
            default: ;
        endcase
    endtask

    // Result side: random ready, long hold-off on request, and the comparison.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    report_mismatch("unexpected report", m_tdata[31:0], 0);
                end else begin
                    weigh_report_t w;
                    w = pending_reports.pop_front();
                    if (m_tdata[31:0] !== w.weight)
                        report_mismatch("weight_grams", $signed(m_tdata[31:0]), w.weight);
                    if (m_tdata[55:32] !== w.median)
                        report_mismatch("median_counts", $signed(m_tdata[55:32]), w.median);
                    if (m_tdata[56] !== w.changing)
                        report_mismatch("weight_changing", m_tdata[56], w.changing);
                    if (m_tdata[57] !== w.slope_err)
                        report_mismatch("slope_error", m_tdata[57], w.slope_err);
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(rx_idling && $urandom_range(99) < 14);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > StallLimit) begin
            $display("FAIL load_cell_median_weigher_unit");
            $finish;
        end
    end

    task automatic test_sample_extremes();
        logic [23:0] edges[7] = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'h000001,
                                  24'hFFFFFF, 24'h555555, 24'hAAAAAA};
        foreach (edges[i]) send_sample(edges[i]);
        repeat (Window) send_sample(24'h7FFFFF);
    endtask

    task automatic test_slope_cases();
        write_reg(RegSlope, 32'd0);
        repeat (Window) send_sample($urandom());
        write_reg(RegSlope, 32'h80000000);
        repeat (Window) send_sample(24'h7FFFFF);
        write_reg(RegTare, 32'h00800000);
        write_reg(RegSlope, 32'd1);
        repeat (Window) send_sample(24'h7FFFFF);
        write_reg(RegSlope, 32'hFFFFFFFF);
        repeat (Window) send_sample(24'h7FFFFF);
        write_reg(RegTare, 32'h007FFFFF);
        write_reg(RegSlope, 32'h7FFFFFFF);
        repeat (Window) send_sample(24'h800000);
    endtask

    task automatic test_disable_keeps_batch();
        write_reg(RegTare, 32'd0);
        write_reg(RegSlope, 32'h00010000);
        write_reg(RegVariance, 32'd0);
        write_reg(RegLimit, 32'd0);
        repeat (3) send_sample($urandom());
        write_reg(RegEnable, 32'd0);
        repeat (4) send_sample($urandom());
        write_reg(RegEnable, 32'd1);
        repeat (4) send_sample($urandom());
    endtask

    task automatic test_random_phases();
        logic [23:0] centre;
        logic [31:0] slope;
        for (int phase = 0; phase < 8; phase++) begin
            slope = $urandom();
            case ($urandom_range(3))
                0: slope = $urandom_range(16, 1) << $urandom_range(20, 10);
                1: slope = -($urandom_range(4000, 1) << 8);
                default: ;
            endcase
            write_reg(RegTare, $urandom());
            write_reg(RegSlope, (phase == 7) ? 32'd0 : slope);
            write_reg(RegVariance, (phase == 0) ? 32'd0 :
                                   (phase == 1) ? 32'hFFFF : $urandom_range(2000));
            write_reg(RegLimit, (phase == 2) ? 32'd255 :
                                (phase == 3) ? 32'd0 : $urandom_range(12));
            centre = $urandom();
            for (int n = 0; n < 56; n++) begin
                if ($urandom_range(9) == 0) centre = $urandom();
                if ($urandom_range(4) == 0)
                    send_sample($urandom());
                else
                    send_sample(centre + 24'($urandom_range(600)) - 24'd300);
                if (phase == 4 && n == 28) wait_for_reports();
            end
        end
    endtask

    task automatic test_output_back_pressure();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        repeat (5 * Window) send_sample($urandom());
        s_tvalid <= 1'b0;
        @(posedge aclk);
        hold_off_cycles <= 1500;
        repeat (4 * Window) send_sample($urandom());
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = RegEnable;
        cfg_data = '0;
        error_count = 0;
        quiet_cycles = 0;
        hold_off_cycles = 0;
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        en_q = 1'b1;
        tare_q = '0;
        slope_q = 32'sh00010000;
        variance_q = 16'd100;
        limit_q = 8'd10;
        batch_fill = 0;
        prior_weight = '0;
        reports_since_change = 0;
        change_on = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_sample_extremes();
        test_slope_cases();
        test_disable_keeps_batch();
        test_output_back_pressure();
        test_random_phases();

        wait_for_reports();
        if (error_count == 0) begin
            $display("PASS load_cell_median_weigher_unit");
        end else begin
            $display("FAIL load_cell_median_weigher_unit");
        end
        $finish;
    end

endmodule
